// ===== rtl/core/sak_pkg.sv =====
package sak_pkg;

    // Fraction bits of the fixed-point format (Q16.16 by default)
    localparam int FRAC_BITS = 16;

    // Configuration register reset values (346.0 and about 1.8 in Q16.16)
    localparam logic [31:0] NOISE_RST = 32'd22675456;
    localparam logic [31:0] RATE_RST  = 32'd117965;

    // Configuration register indexes
    localparam int CFG_IW = 8;
    localparam logic [CFG_IW-1:0] CFG_NOISE = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_RATE  = 8'd1;

    // Datapath operations, one per microcode step
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_DIV  = 3'd1,
        OP_GFIX = 3'd2,
        OP_MUL1 = 3'd3,
        OP_DMAG = 3'd4,
        OP_EST  = 3'd5,
        OP_ERR  = 3'd6,
        OP_OUT  = 3'd7
    } t_op;

    // Jump conditions
    typedef enum logic [1:0] {
        C_NONE = 2'd0,
        C_NOIN = 2'd1,
        C_CNT  = 2'd2,
        C_OBLK = 2'd3
    } t_cond;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_IDLE = 3'd0;
    localparam t_pc PC_DIV  = 3'd1;
    localparam t_pc PC_GFIX = 3'd2;
    localparam t_pc PC_MUL1 = 3'd3;
    localparam t_pc PC_DMAG = 3'd4;
    localparam t_pc PC_EST  = 3'd5;
    localparam t_pc PC_ERR  = 3'd6;
    localparam t_pc PC_OUT  = 3'd7;

    // One control word: operation, condition, taken target, fall-through,
    // and whether the operation is skipped while the condition holds
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        t_pc   tgt;
        t_pc   nxt;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic en;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic cnt_nz;
        logic out_blk;
    } t_stat;

    // Microcode program
    function automatic t_uword urom(input t_pc pc);
        t_uword w;
        case (pc)
            PC_IDLE: w = '{OP_LOAD, C_NOIN, 1'b1, PC_IDLE, PC_DIV};
            PC_DIV:  w = '{OP_DIV,  C_CNT,  1'b0, PC_DIV,  PC_GFIX};
            PC_GFIX: w = '{OP_GFIX, C_NONE, 1'b0, PC_IDLE, PC_MUL1};
            PC_MUL1: w = '{OP_MUL1, C_NONE, 1'b0, PC_IDLE, PC_DMAG};
            PC_DMAG: w = '{OP_DMAG, C_NONE, 1'b0, PC_IDLE, PC_EST};
            PC_EST:  w = '{OP_EST,  C_NONE, 1'b0, PC_IDLE, PC_ERR};
            PC_ERR:  w = '{OP_ERR,  C_NONE, 1'b0, PC_IDLE, PC_OUT};
            PC_OUT:  w = '{OP_OUT,  C_OBLK, 1'b1, PC_OUT,  PC_IDLE};
            default: w = '{OP_LOAD, C_NOIN, 1'b1, PC_IDLE, PC_DIV};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/sak_useq.sv =====
module sak_useq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sak_pkg::t_stat i_stat,
    output logic          o_idle,
    output sak_pkg::t_ctrl o_ctrl
);

    sak_pkg::t_pc    r_pc;
    sak_pkg::t_pc    n_pc;
    sak_pkg::t_uword w;
    logic            cond_true;

    assign w = sak_pkg::urom(r_pc);

    // Condition select
    always_comb begin
        case (w.cond)
            sak_pkg::C_NONE: cond_true = 1'b0;
            sak_pkg::C_NOIN: cond_true = !i_valid;
            sak_pkg::C_CNT:  cond_true = i_stat.cnt_nz;
            sak_pkg::C_OBLK: cond_true = i_stat.out_blk;
            default:         cond_true = 1'b0;
        endcase
    end

    assign n_pc      = cond_true ? w.tgt : w.nxt;
    assign o_idle    = (r_pc == sak_pkg::PC_IDLE);
    assign o_ctrl.op = w.op;
    assign o_ctrl.en = !(w.hold && cond_true);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sak_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/sak_dpath.sv =====
module sak_dpath #(
    parameter int FRAC_BITS = sak_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sak_pkg::t_ctrl     i_ctrl,
    output sak_pkg::t_stat     o_stat,
    input  logic signed [31:0] i_sample,
    input  logic [31:0]        i_noise,
    input  logic [31:0]        i_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_estimate
);

    localparam int GW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [GW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0]   HALF = 64'(1) << (FRAC_BITS - 1);

    logic signed [31:0] r_last;
    logic [31:0]        r_p;
    logic [32:0]        r_den;
    logic [33:0]        r_rem;
    logic [GW-1:0]      r_quo;
    logic [GW-1:0]      r_gain;
    logic [CW-1:0]      r_cnt;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [31:0]        r_dmag;
    logic [32:0]        r_shr;
    logic [63:0]        r_prod;
    logic signed [31:0] r_est;
    logic               r_out_valid;
    logic signed [31:0] r_estimate;

    logic [32:0] diff;
    logic [32:0] mag_w;
    logic        ge;
    logic [33:0] rem_sub;
    logic [63:0] rnd;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic [33:0] est_w;
    logic [63:0] perr;
    logic        run;

    assign run = i_ctrl.en;

    // Difference to the last estimate, sign and magnitude
    assign diff  = {i_sample[31], i_sample} - {r_last[31], r_last};
    assign mag_w = diff[32] ? (33'd0 - diff) : diff;

    // Restoring divide step
    assign ge      = (r_rem >= {1'b0, r_den});
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // Rounded product
    assign rnd = (r_prod + HALF) >> FRAC_BITS;

    // Shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (i_ctrl.op)
            sak_pkg::OP_MUL1: begin
                mul_en = 1'b1;
                mul_a  = r_mag;
                mul_b  = 32'(r_gain);
            end
            sak_pkg::OP_DMAG: begin
                mul_en = 1'b1;
                mul_a  = r_p;
                mul_b  = 32'(ONE - r_gain);
            end
            sak_pkg::OP_EST: begin
                mul_en = 1'b1;
                mul_a  = r_dmag;
                mul_b  = i_rate;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Estimate update, with saturation
    assign est_w = r_neg ? ({{2{r_last[31]}}, r_last} - {2'b00, r_dmag})
                         : ({{2{r_last[31]}}, r_last} + {2'b00, r_dmag});

    // New error term
    assign perr = {31'd0, r_shr} + rnd;

    assign o_stat.cnt_nz  = (r_cnt != '0);
    assign o_stat.out_blk = r_out_valid && !i_ready;

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_ctrl.op)
            sak_pkg::OP_LOAD: begin
                if (run) begin
                    r_den <= {1'b0, r_p} + {1'b0, i_noise};
                    r_rem <= {2'b00, r_p};
                    r_quo <= '0;
                    r_cnt <= CW'(FRAC_BITS);
                    r_mag <= mag_w[31:0];
                    r_neg <= diff[32];
                end
            end
            sak_pkg::OP_DIV: begin
                r_rem <= {rem_sub[32:0], 1'b0};
                r_quo <= {r_quo[GW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
            end
            sak_pkg::OP_GFIX: begin
                if (r_den == '0) begin
                    r_gain <= '0;
                end else if (r_quo > ONE) begin
                    r_gain <= ONE;
                end else begin
                    r_gain <= r_quo;
                end
            end
            sak_pkg::OP_DMAG: begin
                r_dmag <= (rnd > {32'd0, r_mag}) ? r_mag : rnd[31:0];
            end
            sak_pkg::OP_EST: begin
                r_shr <= rnd[32:0];
                if (!est_w[33] && est_w[32:31] != 2'b00) begin
                    r_est <= 32'sh7FFFFFFF;
                end else if (est_w[33] && est_w[32:31] != 2'b11) begin
                    r_est <= 32'sh80000000;
                end else begin
                    r_est <= est_w[31:0];
                end
            end
            sak_pkg::OP_OUT: begin
                if (run) begin
                    r_estimate <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

    // Filter state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_p         <= sak_pkg::NOISE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == sak_pkg::OP_ERR) begin
                r_last <= r_est;
                r_p    <= (perr[63:32] != '0) ? 32'hFFFFFFFF : perr[31:0];
            end
            if (i_ctrl.op == sak_pkg::OP_OUT && run) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_estimate = r_estimate;

endmodule

// ===== rtl/core/scalar_adaptive_kalman_smoother.sv =====
// Scalar Kalman smoother: one signed fixed-point sample in, one estimate out.
// Gain is error/(error+noise), found by a restoring divider that resolves one
// quotient bit per cycle; a single shared 32x32 multiplier then forms the
// correction, the error shrink and the error growth. A microcoded sequencer
// steps the datapath and takes no new sample until the last item has run
// through the divide loop and reached the output register. The error term
// is set to NOISE_RST only at reset; configuration writes are taken only
// while the filter is idle, and a pending write holds off the next sample
// request for that cycle.
module scalar_adaptive_kalman_smoother #(
    parameter int FRAC_BITS = sak_pkg::FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [31:0]        i_sample,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [31:0]        o_estimate,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sak_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data
);

    logic [31:0]    r_noise;
    logic [31:0]    r_rate;
    sak_pkg::t_ctrl ctrl;
    sak_pkg::t_stat stat;
    logic           idle;
    logic           in_req;

    // Writes only between items; a write wins over a sample in the same cycle
    assign o_cfg_ready = idle;
    assign o_ready     = idle && !i_cfg_valid;
    assign in_req      = i_valid && !i_cfg_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= sak_pkg::NOISE_RST;
            r_rate  <= sak_pkg::RATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == sak_pkg::CFG_NOISE) begin
                r_noise <= i_cfg_data;
            end else if (i_cfg_index == sak_pkg::CFG_RATE) begin
                r_rate <= i_cfg_data;
            end
        end
    end

    sak_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_req),
        .i_stat  (stat),
        .o_idle  (idle),
        .o_ctrl  (ctrl)
    );

    sak_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_sample   (i_sample),
        .i_noise    (r_noise),
        .i_rate     (r_rate),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_estimate (o_estimate)
    );

endmodule
